// ===== sv/sfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrf_pkg
// Shared constants, codes and types of the sync frame receiver with
// Fletcher-8 check.
// ----------------------------------------------------------------------------
package sfrf_pkg;

  // payload store geometry
  localparam int MAX_PAYLOAD   = 64;
  localparam int PAY_AW        = $clog2(MAX_PAYLOAD);
  localparam int LEN_W         = PAY_AW + 1;

  // message table
  localparam int TABLE_ENTRIES = 6;
  localparam int ENT_CODE_W    = 16;
  localparam int ENT_LEN_LSB   = 16;
  localparam int ENT_LEN_W     = 8;
  localparam int ENT_EN_BIT    = 24;

  // configuration port
  localparam int CFG_IW        = 3;
  localparam int CFG_DW        = 25;
  localparam int SYNC_W        = 16;
  localparam logic [SYNC_W-1:0] SYNC_RESET = 16'h62B5;

  localparam logic [CFG_IW-1:0] REG_SYNC   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ENTRY0 = 3'd1;

  // result fields
  localparam int ST_W   = 3;
  localparam int BIDX_W = 6;

  localparam logic [ST_W-1:0] ST_PAYLOAD = 3'd0;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd1;
  localparam logic [ST_W-1:0] ST_LENGTH  = 3'd2;
  localparam logic [ST_W-1:0] ST_CKA     = 3'd3;
  localparam logic [ST_W-1:0] ST_CKB     = 3'd4;

  // table lookup answer
  typedef struct packed {
    logic                 hit;
    logic [ENT_LEN_W-1:0] exp_len;
  } lkup_t;

  // payload store access
  typedef struct packed {
    logic              we;
    logic [PAY_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [PAY_AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/sfrf_in_if.sv =====
// ----------------------------------------------------------------------------
// sfrf_in_if
// Received byte channel: one serial byte per word.
// ----------------------------------------------------------------------------
interface sfrf_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sfrf_out_if.sv =====
// ----------------------------------------------------------------------------
// sfrf_out_if
// Result channel: payload bytes of good frames and drop status words.
// ----------------------------------------------------------------------------
interface sfrf_out_if import sfrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [7:0]        msg_class;
  logic [7:0]        msg_id;
  logic [7:0]        payload_byte;
  logic [BIDX_W-1:0] byte_index;
  logic              last;

  modport source (output valid, output status, output msg_class, output msg_id,
                  output payload_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input status, input msg_class, input msg_id,
                  input payload_byte, input byte_index, input last,
                  output ready);
endinterface

// ===== sv/sfrf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sfrf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfrf_cfg_if import sfrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sfrf_ram.sv =====
// ----------------------------------------------------------------------------
// sfrf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfrf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port: hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sfrf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sfrf_cfg_regs
// Sync word and message table registers, plus the class/id table lookup.
// ----------------------------------------------------------------------------
module sfrf_cfg_regs import sfrf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sfrf_cfg_if.sink              cfg_if,
  input  logic [ENT_CODE_W-1:0] code,
  output logic [7:0]            sync1,
  output logic [7:0]            sync2,
  output lkup_t                 lkup
);

  logic [SYNC_W-1:0] sync_r;
  logic [CFG_DW-1:0] entry_r [TABLE_ENTRIES];

  // writes are always taken
  assign cfg_if.ready = 1'b1;

  // register writes; indexes past the table are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_r[i] <= '0;
      end
    end else if (cfg_if.valid) begin
      if (cfg_if.index == REG_SYNC) begin
        sync_r <= cfg_if.data[SYNC_W-1:0];
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cfg_if.index == CFG_IW'(int'(REG_ENTRY0) + i)) begin
          entry_r[i] <= cfg_if.data;
        end
      end
    end
  end

  assign sync1 = sync_r[7:0];
  assign sync2 = sync_r[15:8];

  // lowest enabled matching entry wins: scan from the top down
  always_comb begin
    lkup = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_r[i][ENT_EN_BIT] && entry_r[i][ENT_CODE_W-1:0] == code) begin
        lkup.hit     = 1'b1;
        lkup.exp_len = entry_r[i][ENT_LEN_LSB +: ENT_LEN_W];
      end
    end
  end

endmodule

// ===== sv/sfrf_parser.sv =====
// ----------------------------------------------------------------------------
// sfrf_parser
// Frame decode state machine with Fletcher-8 sums, payload store writes and
// the store readout sequencer feeding the result register.
// ----------------------------------------------------------------------------
module sfrf_parser import sfrf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sfrf_in_if.sink               in_if,
  sfrf_out_if.source            out_if,
  input  logic [7:0]            sync1,
  input  logic [7:0]            sync2,
  input  lkup_t                 lkup,
  output logic [ENT_CODE_W-1:0] code,
  output ram_req_t              ram_req,
  input  logic [7:0]            ram_rdata
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;
  localparam logic [3:0] PH_READ    = 4'd9;

  logic [3:0]       phase_r,    phase_nxt;
  logic [7:0]       sum_a_r,    sum_a_nxt;
  logic [7:0]       sum_b_r,    sum_b_nxt;
  logic [7:0]       class_r,    class_nxt;
  logic [7:0]       id_r,       id_nxt;
  logic [7:0]       len_lo_r,   len_lo_nxt;
  logic [LEN_W-1:0] frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0] fill_r,     fill_nxt;
  logic [LEN_W-1:0] iss_r,      iss_nxt;
  logic [LEN_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             pend_r,     pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [7:0]        out_class_r, out_class_nxt;
  logic [7:0]        out_id_r,    out_id_nxt;
  logic [7:0]        out_pbyte_r, out_pbyte_nxt;
  logic [BIDX_W-1:0] out_bidx_r,  out_bidx_nxt;
  logic              out_last_r,  out_last_nxt;

  logic             out_free;
  logic             in_fire;
  logic [7:0]       b;
  logic [7:0]       sa_add;
  logic [7:0]       sb_add;
  logic [15:0]      len_full;
  logic [LEN_W-1:0] fill_inc;
  logic             load;
  logic             issue;

  // result register frees when empty or taken this cycle
  assign out_free     = !out_valid_r || out_if.ready;
  assign in_if.ready  = (phase_r != PH_READ) && out_free;
  assign in_fire      = in_if.valid && in_if.ready;
  assign b            = in_if.rx_byte;

  // Fletcher-8 running sums
  assign sa_add   = sum_a_r + b;
  assign sb_add   = sum_b_r + sa_add;
  assign len_full = {b, len_lo_r};
  assign fill_inc = fill_r + LEN_W'(1);
  assign code     = {id_r, class_r};

  // readout: store reads happen only after the frame is fully written,
  // so reads and writes never overlap on one entry
  assign load  = pend_r && out_free;
  assign issue = (phase_r == PH_READ) && (iss_r < frame_len_r) && (!pend_r || load);

  always_comb begin
    phase_nxt      = phase_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    class_nxt      = class_r;
    id_nxt         = id_r;
    len_lo_nxt     = len_lo_r;
    frame_len_nxt  = frame_len_r;
    fill_nxt       = fill_r;
    iss_nxt        = iss_r;
    pend_idx_nxt   = pend_idx_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_class_nxt  = out_class_r;
    out_id_nxt     = out_id_r;
    out_pbyte_nxt  = out_pbyte_r;
    out_bidx_nxt   = out_bidx_r;
    out_last_nxt   = out_last_r;
    ram_req        = '0;
    ram_req.waddr  = fill_r[PAY_AW-1:0];
    ram_req.wdata  = b;
    ram_req.raddr  = iss_r[PAY_AW-1:0];

    // decode one received word
    if (in_fire) begin
      out_class_nxt = class_r;
      out_id_nxt    = id_r;
      out_pbyte_nxt = '0;
      out_bidx_nxt  = '0;
      out_last_nxt  = 1'b1;
      case (phase_r)
        PH_SYNC1: begin
          if (b == sync1) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (b == sync2) begin
            phase_nxt = PH_CLASS;
          end else begin
            phase_nxt = PH_SYNC1;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
            len_lo_nxt = '0;
            frame_len_nxt = '0;
            fill_nxt = '0;
          end
        end
        PH_CLASS: begin
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          class_nxt = b;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          id_nxt    = b;
          phase_nxt = PH_LEN1;
        end
        PH_LEN1: begin
          sum_a_nxt  = sa_add;
          sum_b_nxt  = sb_add;
          len_lo_nxt = b;
          phase_nxt  = PH_LEN2;
        end
        PH_LEN2: begin
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          if (!lkup.hit ||
              len_full != {8'h00, lkup.exp_len} ||
              len_full > 16'(MAX_PAYLOAD)) begin
            // drop: report and restart hunt
            out_valid_nxt  = 1'b1;
            out_status_nxt = lkup.hit ? ST_LENGTH : ST_UNKNOWN;
            phase_nxt      = PH_SYNC1;
            sum_a_nxt      = '0;
            sum_b_nxt      = '0;
            len_lo_nxt     = '0;
            frame_len_nxt  = '0;
            fill_nxt       = '0;
          end else begin
            frame_len_nxt = LEN_W'(len_lo_r);
            fill_nxt      = '0;
            phase_nxt     = (len_lo_r == 8'h00) ? PH_CKA : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt  = sa_add;
          sum_b_nxt  = sb_add;
          ram_req.we = 1'b1;
          fill_nxt   = fill_inc;
          if (fill_inc >= frame_len_r) begin
            phase_nxt = PH_CKA;
          end
        end
        PH_CKA: begin
          if (b != sum_a_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CKA;
            phase_nxt      = PH_SYNC1;
            sum_a_nxt      = '0;
            sum_b_nxt      = '0;
            len_lo_nxt     = '0;
            frame_len_nxt  = '0;
            fill_nxt       = '0;
          end else begin
            phase_nxt = PH_CKB;
          end
        end
        PH_CKB: begin
          sum_a_nxt  = '0;
          sum_b_nxt  = '0;
          len_lo_nxt = '0;
          fill_nxt   = '0;
          if (b != sum_b_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CKB;
            phase_nxt      = PH_SYNC1;
            frame_len_nxt  = '0;
          end else if (frame_len_r == '0) begin
            phase_nxt = PH_SYNC1;
          end else begin
            // good frame: start store readout
            phase_nxt = PH_READ;
            iss_nxt   = '0;
            pend_nxt  = 1'b0;
          end
        end
        default: begin
          phase_nxt     = PH_SYNC1;
          sum_a_nxt     = '0;
          sum_b_nxt     = '0;
          len_lo_nxt    = '0;
          frame_len_nxt = '0;
          fill_nxt      = '0;
        end
      endcase
    end

    // advance store readout
    if (phase_r == PH_READ) begin
      if (issue) begin
        ram_req.re   = 1'b1;
        iss_nxt      = iss_r + LEN_W'(1);
        pend_idx_nxt = iss_r;
      end
      pend_nxt = issue ? 1'b1 : (load ? 1'b0 : pend_r);
      if (load) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_PAYLOAD;
        out_class_nxt  = class_r;
        out_id_nxt     = id_r;
        out_pbyte_nxt  = ram_rdata;
        out_bidx_nxt   = pend_idx_r[BIDX_W-1:0];
        out_last_nxt   = (pend_idx_r + LEN_W'(1)) == frame_len_r;
        if ((pend_idx_r + LEN_W'(1)) == frame_len_r) begin
          phase_nxt     = PH_SYNC1;
          frame_len_nxt = '0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      class_r     <= '0;
      id_r        <= '0;
      len_lo_r    <= '0;
      frame_len_r <= '0;
      fill_r      <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      class_r     <= class_nxt;
      id_r        <= id_nxt;
      len_lo_r    <= len_lo_nxt;
      frame_len_r <= frame_len_nxt;
      fill_r      <= fill_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_class_r  <= out_class_nxt;
    out_id_r     <= out_id_nxt;
    out_pbyte_r  <= out_pbyte_nxt;
    out_bidx_r   <= out_bidx_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.msg_class    = out_class_r;
  assign out_if.msg_id       = out_id_r;
  assign out_if.payload_byte = out_pbyte_r;
  assign out_if.byte_index   = out_bidx_r;
  assign out_if.last         = out_last_r;

endmodule

// ===== sv/sync_frame_receiver_fletcher.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_fletcher
// Sync-framed message receiver with Fletcher-8 check and payload readout.
//
//   channel  direction  word contents
//   in_if    sink       rx_byte
//   out_if   source     status, msg_class, msg_id, payload_byte, byte_index, last
//   cfg_if   sink       index (0 sync word, 1..6 table entries), data
//
// One received byte is taken per cycle while no payload readout runs.
// A good frame then streams its payload from the store at one byte per cycle
// while results are taken, through the single registered read port; input
// is held off during the readout. Results wait in one output register, and a
// stalled result holds off the next input byte. Reset is synchronous; the
// payload store needs no clearing since a frame only reads what it wrote.
// ----------------------------------------------------------------------------
module sync_frame_receiver_fletcher import sfrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sfrf_in_if.sink    in_if,
  sfrf_out_if.source out_if,
  sfrf_cfg_if.sink   cfg_if
);

  logic [7:0]            sync1;
  logic [7:0]            sync2;
  lkup_t                 lkup;
  logic [ENT_CODE_W-1:0] code;
  ram_req_t              ram_req;
  logic [7:0]            ram_rdata;

  // configuration and message table
  sfrf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .code   (code),
    .sync1  (sync1),
    .sync2  (sync2),
    .lkup   (lkup)
  );

  // frame decoder and readout
  sfrf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .sync1     (sync1),
    .sync2     (sync2),
    .lkup      (lkup),
    .code      (code),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // payload store
  sfrf_ram #(
    .DEPTH (MAX_PAYLOAD),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== sim/sync_frame_receiver_fletcher_test.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_fletcher_test
// Self-checking bench for the sync frame receiver. A local parser model
// predicts every result word from the accepted bytes and the register
// shadow. Stimulus runs a short directed list and then several phases of
// random frames. Each phase has its own register set; most idle both channels
// at random, and the last adds one long receiver hold-off backing up input.
// ----------------------------------------------------------------------------
module sync_frame_receiver_fletcher_test import sfrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic [3:0] {
    HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
    GET_PAYLOAD, GET_CK_A, GET_CK_B
  } rx_phase_e;

  typedef enum int {FRAME_GOOD, FRAME_BAD_A, FRAME_BAD_B, FRAME_HEADER} frame_kind_e;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [7:0]        msg_class;
    logic [7:0]        msg_id;
    logic [7:0]        payload_byte;
    logic [BIDX_W-1:0] byte_index;
    logic              last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sfrf_in_if  in_ch ();
  sfrf_out_if out_ch ();
  sfrf_cfg_if cfg_ch ();

  sync_frame_receiver_fletcher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk = ~clk;

  // register shadow and parser state
  logic [SYNC_W-1:0] cfg_sync = SYNC_RESET;
  logic [CFG_DW-1:0] cfg_entry [TABLE_ENTRIES] = '{default: '0};
  logic [CFG_DW-1:0] table_plan [TABLE_ENTRIES];
  rx_phase_e         rx_phase = HUNT_SYNC1;
  logic [7:0]        sum_a = '0;
  logic [7:0]        sum_b = '0;
  logic [7:0]        frame_class = '0;
  logic [7:0]        frame_id = '0;
  logic [15:0]       frame_len = '0;
  logic [6:0]        fill_idx = '0;
  logic [7:0]        payload_copy [MAX_PAYLOAD];

  result_word_t results_due [$];
  logic [7:0]   rx_backlog [$];
  int           bytes_queued = 0;

  int   cycle_count = 0;
  int   err_count = 0;
  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   ready_gap = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  logic no_idle = 1'b0;

  // -------------------------------------------------------------------------
  // parser model
  // -------------------------------------------------------------------------
  function automatic void due_word(input logic [ST_W-1:0] st, input logic [7:0] pb,
                                   input logic [BIDX_W-1:0] idx, input logic lst);
    results_due.push_back({st, frame_class, frame_id, pb, idx, lst});
  endfunction

  function automatic void restart_hunt();
    rx_phase  = HUNT_SYNC1;
    sum_a     = '0;
    sum_b     = '0;
    frame_len = '0;
    fill_idx  = '0;
  endfunction

  function automatic void add_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // first enabled entry with the frame's code decides
  function automatic logic [ST_W-1:0] lookup_status();
    logic [CFG_DW-1:0] e;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      e = cfg_entry[i];
      if (e[ENT_EN_BIT] && e[ENT_CODE_W-1:0] == {frame_id, frame_class}) begin
        if (frame_len != {8'h00, e[ENT_LEN_LSB +: ENT_LEN_W]}) return ST_LENGTH;
        if (frame_len > MAX_PAYLOAD) return ST_LENGTH;
        return ST_PAYLOAD;
      end
    end
    return ST_UNKNOWN;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [ST_W-1:0] st;
    int n;
    case (rx_phase)
      HUNT_SYNC1: begin
        if (b == cfg_sync[7:0]) rx_phase = HUNT_SYNC2;
      end
      HUNT_SYNC2: begin
        if (b == cfg_sync[15:8]) rx_phase = GET_CLASS;
        else restart_hunt();
      end
      GET_CLASS: begin
        add_sum(b);
        frame_class = b;
        rx_phase = GET_ID;
      end
      GET_ID: begin
        add_sum(b);
        frame_id = b;
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        add_sum(b);
        frame_len = {8'h00, b};
        rx_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        add_sum(b);
        frame_len[15:8] = b;
        st = lookup_status();
        if (st != ST_PAYLOAD) begin
          due_word(st, 8'h00, '0, 1'b1);
          restart_hunt();
        end else begin
          fill_idx = '0;
          rx_phase = (frame_len != 0) ? GET_PAYLOAD : GET_CK_A;
        end
      end
      GET_PAYLOAD: begin
        add_sum(b);
        if (fill_idx < MAX_PAYLOAD) payload_copy[fill_idx[PAY_AW-1:0]] = b;
        fill_idx = fill_idx + 1'b1;
        if ({9'd0, fill_idx} >= frame_len) rx_phase = GET_CK_A;
      end
      GET_CK_A: begin
        if (b != sum_a) begin
          due_word(ST_CKA, 8'h00, '0, 1'b1);
          restart_hunt();
        end else begin
          rx_phase = GET_CK_B;
        end
      end
      GET_CK_B: begin
        if (b != sum_b) begin
          due_word(ST_CKB, 8'h00, '0, 1'b1);
        end else begin
          n = (frame_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(frame_len);
          for (int i = 0; i < n; i++)
            due_word(ST_PAYLOAD, payload_copy[i], BIDX_W'(i), i == n - 1);
        end
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------
  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_word();
    result_word_t got, want;
    got = {out_ch.status, out_ch.msg_class, out_ch.msg_id, out_ch.payload_byte,
           out_ch.byte_index, out_ch.last};
    if (results_due.size() == 0) begin
      flag_error($sformatf("unexpected word status %0d class %02h id %02h",
                           got.status, got.msg_class, got.msg_id));
      return;
    end
    want = results_due.pop_front();
    if (got.status !== want.status)
      flag_error($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.msg_class !== want.msg_class)
      flag_error($sformatf("msg_class %02h, want %02h", got.msg_class, want.msg_class));
    if (got.msg_id !== want.msg_id)
      flag_error($sformatf("msg_id %02h, want %02h", got.msg_id, want.msg_id));
    if (got.payload_byte !== want.payload_byte)
      flag_error($sformatf("payload_byte %02h, want %02h", got.payload_byte,
                           want.payload_byte));
    if (got.byte_index !== want.byte_index)
      flag_error($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
    if (got.last !== want.last)
      flag_error($sformatf("last %0b, want %0b", got.last, want.last));
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken    <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (in_ch.valid && in_ch.ready) parse_rx_byte(in_ch.rx_byte);
    end
  end

  // -------------------------------------------------------------------------
  // channel drivers
  // -------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advance to the next byte once the current word is taken
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (rx_backlog.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx_backlog.pop_front();
        send_gap      <= no_idle ? 0 : draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // count down a long receiver hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // stall the result channel at random
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else if (ready_gap != 0) begin
      out_ch.ready <= 1'b0;
      ready_gap    <= ready_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      ready_gap    <= no_idle ? 0 : draw_gap();
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void queue_summed(input logic [7:0] b, inout logic [7:0] ca,
                                       inout logic [7:0] cb);
    queue_byte(b);
    ca = ca + b;
    cb = cb + ca;
  endfunction

  // one frame under the current sync word; header-only frames stop at length
  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input frame_kind_e kind);
    logic [7:0] ca, cb;
    ca = '0;
    cb = '0;
    queue_byte(cfg_sync[7:0]);
    queue_byte(cfg_sync[15:8]);
    queue_summed(cls, ca, cb);
    queue_summed(id, ca, cb);
    queue_summed(len[7:0], ca, cb);
    queue_summed(len[15:8], ca, cb);
    if (kind == FRAME_HEADER) return;
    for (int i = 0; i < int'(len); i++) queue_summed(8'($urandom), ca, cb);
    queue_byte(kind == FRAME_BAD_A ? ca ^ 8'($urandom_range(1, 255)) : ca);
    if (kind == FRAME_BAD_A) return;
    queue_byte(kind == FRAME_BAD_B ? cb ^ 8'($urandom_range(1, 255)) : cb);
  endtask

  // mostly well-formed frames against the loaded table, some noise
  task automatic queue_traffic(input int budget);
    int start, r, k, w;
    logic [CFG_DW-1:0] e;
    logic [ENT_LEN_W-1:0] wl;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, TABLE_ENTRIES - 1);
      e = cfg_entry[k];
      if (r < 60) begin
        w = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (w < 0 && cfg_entry[i][ENT_EN_BIT] &&
              cfg_entry[i][ENT_CODE_W-1:0] == e[ENT_CODE_W-1:0]) w = i;
        if (w < 0) begin
          queue_frame(e[7:0], e[15:8], 16'($urandom_range(0, 8)), FRAME_HEADER);
        end else begin
          wl = cfg_entry[w][ENT_LEN_LSB +: ENT_LEN_W];
          if (wl > MAX_PAYLOAD) begin
            queue_frame(e[7:0], e[15:8], {8'h00, wl}, FRAME_HEADER);
          end else begin
            r = $urandom_range(0, 9);
            queue_frame(e[7:0], e[15:8], {8'h00, wl},
                        r < 8 ? FRAME_GOOD : (r == 8 ? FRAME_BAD_A : FRAME_BAD_B));
          end
        end
      end else if (r < 75) begin
        queue_frame(e[7:0], e[15:8],
                    {8'h00, e[ENT_LEN_LSB +: ENT_LEN_W]} + 16'($urandom_range(1, 300)),
                    FRAME_HEADER);
      end else if (r < 85) begin
        queue_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 70)), FRAME_HEADER);
      end else if (r < 93) begin
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
      end else begin
        // sync1 then a broken second byte
        queue_byte(cfg_sync[7:0]);
        queue_byte(8'($urandom));
      end
    end
  endtask

  function automatic logic [CFG_DW-1:0] make_entry();
    logic [7:0] cls, id, len;
    int r;
    cls = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'($urandom);
    id  = ($urandom_range(0, 1) != 0) ? 8'h02 : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70)      len = 8'($urandom_range(0, 6));
    else if (r < 85) len = 8'($urandom_range(7, 20));
    else if (r < 95) len = 8'(MAX_PAYLOAD);
    else             len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    return {$urandom_range(0, 9) < 8, len, id, cls};
  endfunction

  // -------------------------------------------------------------------------
  // register writes
  // -------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_SYNC) cfg_sync = val[SYNC_W-1:0];
    else cfg_entry[int'(idx) - int'(REG_ENTRY0)] = val;
  endtask

  task automatic load_config(input logic [SYNC_W-1:0] sync);
    write_reg(REG_SYNC, {{(CFG_DW - SYNC_W){1'b0}}, sync});
    for (int i = 0; i < TABLE_ENTRIES; i++)
      write_reg(CFG_IW'(int'(REG_ENTRY0) + i), table_plan[i]);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold until the backlog is sent and every due word has arrived
  task automatic wait_idle();
    logic done;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (rx_backlog.size() == 0 && !in_ch.valid) begin
        @(negedge clk);
        done = (results_due.size() == 0);
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // run sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sync restart, empty frame, every drop status
    table_plan[0] = {1'b1, 8'd0, 8'h07, 8'h01};
    table_plan[1] = {1'b1, 8'd1, 8'h0A, 8'h05};
    table_plan[2] = {1'b0, 8'd0, 8'h02, 8'h02};
    table_plan[3] = {1'b1, 8'd3, 8'h07, 8'h01};
    table_plan[4] = {1'b1, 8'd65, 8'h09, 8'h09};
    table_plan[5] = '0;
    load_config(SYNC_RESET);
    queue_byte(cfg_sync[7:0]);
    queue_byte(cfg_sync[7:0]);
    queue_byte(cfg_sync[15:8]);
    queue_frame(8'h01, 8'h07, 16'd0, FRAME_GOOD);
    queue_frame(8'h02, 8'h02, 16'd0, FRAME_HEADER);
    queue_frame(8'h01, 8'h07, 16'd3, FRAME_HEADER);
    queue_frame(8'h09, 8'h09, 16'd65, FRAME_HEADER);
    queue_frame(8'h01, 8'h07, 16'd0, FRAME_BAD_A);
    queue_frame(8'h05, 8'h0A, 16'd1, FRAME_BAD_B);
    wait_idle();

    // random table under the reset sync word
    for (int i = 0; i < TABLE_ENTRIES; i++) table_plan[i] = make_entry();
    load_config(SYNC_RESET);
    queue_traffic(40);
    wait_idle();

    // extreme codes and sync bytes, no idling on either side
    table_plan[0] = {1'b1, 8'd0, 16'h0000};
    table_plan[1] = {1'b1, 8'd64, 16'hFFFF};
    table_plan[2] = {1'b1, 8'd5, 16'h0000};
    table_plan[3] = {CFG_DW{1'b1}};
    table_plan[4] = {1'b1, 8'd1, 16'h00FF};
    table_plan[5] = {1'b0, 8'd0, 16'hFF00};
    load_config(16'hFFFF);
    no_idle = 1'b1;
    queue_traffic(30);
    wait_idle();
    no_idle = 1'b0;

    // zero sync word, half fully random entries
    for (int i = 0; i < TABLE_ENTRIES; i++)
      table_plan[i] = (i % 2 == 0) ? CFG_DW'($urandom) : make_entry();
    load_config(16'h0000);
    queue_traffic(30);
    wait_idle();

    // full-size frame while the receiver holds off
    for (int i = 1; i < TABLE_ENTRIES; i++) table_plan[i] = make_entry();
    table_plan[0] = {1'b1, 8'(MAX_PAYLOAD), 16'($urandom)};
    load_config(16'($urandom));
    queue_frame(table_plan[0][7:0], table_plan[0][15:8], 16'(MAX_PAYLOAD), FRAME_GOOD);
    hold_seq++;
    queue_traffic(20);
    wait_idle();

    if (results_due.size() != 0)
      flag_error($sformatf("%0d result words never arrived", results_due.size()));
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // give up on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sfrf_pkg.sv
sv/sfrf_in_if.sv
sv/sfrf_out_if.sv
sv/sfrf_cfg_if.sv
sv/sfrf_ram.sv
sv/sfrf_cfg_regs.sv
sv/sfrf_parser.sv
sv/sync_frame_receiver_fletcher.sv
sim/sync_frame_receiver_fletcher_test.sv
